### rtl/calu_pkg.sv
// ----------------------------------------------------------------------------
// calu_pkg: shared types and constants for the 8-bit CPU ALU
// Operation codes, flag bit positions and bus widths.
// ----------------------------------------------------------------------------
package calu_pkg;

  localparam int unsigned OpW    = 5;
  localparam int unsigned WordW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned FlagW  = 4;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InPackW  = OpW + 2 * WordW + IdxW + FlagW;
  localparam int unsigned InDataW  = ((InPackW + 7) / 8) * 8;
  localparam int unsigned OutPackW = WordW + FlagW;
  localparam int unsigned OutDataW = ((OutPackW + 7) / 8) * 8;

  // Flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [OpW-1:0] {
    OP_ADD16S8 = 5'd0,
    OP_ADD16   = 5'd1,
    OP_ADD     = 5'd2,
    OP_ADC     = 5'd3,
    OP_SUB     = 5'd4,
    OP_SBC     = 5'd5,
    OP_AND     = 5'd6,
    OP_XOR     = 5'd7,
    OP_OR      = 5'd8,
    OP_CP      = 5'd9,
    OP_INC     = 5'd10,
    OP_DEC     = 5'd11,
    OP_DAA     = 5'd12,
    OP_CPL     = 5'd13,
    OP_SCF     = 5'd14,
    OP_CCF     = 5'd15,
    OP_BIT     = 5'd16,
    OP_RES     = 5'd17,
    OP_SET     = 5'd18,
    OP_RLC     = 5'd19,
    OP_RRC     = 5'd20,
    OP_RL      = 5'd21,
    OP_RR      = 5'd22,
    OP_SLA     = 5'd23,
    OP_SRA     = 5'd24,
    OP_SWAP    = 5'd25,
    OP_SRL     = 5'd26
  } alu_op_e;

  // One operation as held in the input register
  typedef struct packed {
    alu_op_e               op;
    logic [WordW-1:0]      operand_a;
    logic [WordW-1:0]      operand_b;
    logic [IdxW-1:0]       bit_index;
    logic [FlagW-1:0]      flags_in;
  } alu_req_t;

  // One result as held in the output register
  typedef struct packed {
    logic [WordW-1:0]      result;
    logic [FlagW-1:0]      flags_out;
  } alu_rsp_t;

endpackage

### rtl/calu_core.sv
// ----------------------------------------------------------------------------
// calu_core: combinational ALU datapath
// Computes result and Z/N/H/C for one operation.
// ----------------------------------------------------------------------------
module calu_core (
  input  calu_pkg::alu_req_t req_i,
  output calu_pkg::alu_rsp_t rsp_o
);
  import calu_pkg::*;

  logic [ByteW-1:0]  a8;
  logic [ByteW-1:0]  b8;
  logic              cin;
  logic [ByteW:0]    sum9;
  logic [ByteW:0]    dif9;
  logic [ByteW:0]    lo9;
  logic [WordW:0]    sum17;
  logic [WordW-1:0]  adds8;
  logic [ByteW-1:0]  mask8;
  logic [ByteW-1:0]  daa_x;
  logic [ByteW-1:0]  r8;
  logic [WordW-1:0]  res;
  logic              fz, fn, fh, fc;
  logic              setz;
  logic              use8;

  assign a8    = req_i.operand_a[ByteW-1:0];
  assign b8    = req_i.operand_b[ByteW-1:0];
  assign cin   = req_i.flags_in[FlagC];
  assign mask8 = ByteW'(1) << req_i.bit_index;
  assign lo9   = {1'b0, a8} + {1'b0, b8};
  assign sum17 = {1'b0, req_i.operand_a} + {1'b0, req_i.operand_b};
  assign adds8 = req_i.operand_a + {{(WordW-ByteW){b8[ByteW-1]}}, b8};
  assign sum9  = {1'b0, a8} + {1'b0, b8}
               + {{ByteW{1'b0}}, cin & (req_i.op == OP_ADC)};
  assign dif9  = {1'b0, a8} - {1'b0, b8}
               - {{ByteW{1'b0}}, cin & (req_i.op == OP_SBC)};

  // DAA correction value
  always_comb begin
    daa_x = '0;
    if (req_i.flags_in[FlagH]) daa_x = daa_x | 8'h06;
    if (req_i.flags_in[FlagC]) daa_x = daa_x | 8'h60;
    if (!req_i.flags_in[FlagN]) begin
      if (a8[3:0] > 4'h9) daa_x = daa_x | 8'h06;
      if (a8 > 8'h99)     daa_x = daa_x | 8'h60;
    end
  end

  always_comb begin
    fz   = req_i.flags_in[FlagZ];
    fn   = req_i.flags_in[FlagN];
    fh   = req_i.flags_in[FlagH];
    fc   = req_i.flags_in[FlagC];
    r8   = a8;
    res  = req_i.operand_a;
    use8 = 1'b0;
    setz = 1'b0;
    unique case (req_i.op)
      OP_ADD16S8: begin
        res = adds8;
        fz  = 1'b0;
        fn  = 1'b0;
        fh  = (a8[4] ^ b8[4] ^ lo9[4]);
        fc  = lo9[ByteW];
      end
      OP_ADD16: begin
        res = sum17[WordW-1:0];
        fn  = 1'b0;
        fh  = req_i.operand_a[12] ^ req_i.operand_b[12] ^ sum17[12];
        fc  = sum17[WordW];
      end
      OP_ADD, OP_ADC: begin
        r8   = sum9[ByteW-1:0];
        use8 = 1'b1;
        fn   = 1'b0;
        fh   = a8[4] ^ b8[4] ^ sum9[4];
        fc   = sum9[ByteW];
        setz = 1'b1;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8   = dif9[ByteW-1:0];
        use8 = (req_i.op != OP_CP);  // compare keeps operand_a
        fn   = 1'b1;
        fh   = a8[4] ^ b8[4] ^ dif9[4];
        fc   = dif9[ByteW];
        fz   = (dif9[ByteW-1:0] == '0);
      end
      OP_AND, OP_XOR, OP_OR: begin
        r8   = (req_i.op == OP_AND) ? (a8 & b8) :
               (req_i.op == OP_XOR) ? (a8 ^ b8) : (a8 | b8);
        use8 = 1'b1;
        fn   = 1'b0;
        fh   = (req_i.op == OP_AND);
        fc   = 1'b0;
        setz = 1'b1;
      end
      OP_INC: begin
        r8   = a8 + 8'd1;
        use8 = 1'b1;
        fn   = 1'b0;
        fh   = (a8[3:0] == 4'hF);
        setz = 1'b1;
      end
      OP_DEC: begin
        r8   = a8 - 8'd1;
        use8 = 1'b1;
        fn   = 1'b1;
        fh   = (a8[3:0] == 4'h0);
        setz = 1'b1;
      end
      OP_DAA: begin
        r8   = req_i.flags_in[FlagN] ? (a8 - daa_x) : (a8 + daa_x);
        use8 = 1'b1;
        fh   = 1'b0;
        fc   = (daa_x[6:5] != 2'b00);
        setz = 1'b1;
      end
      OP_CPL: begin
        r8   = ~a8;
        use8 = 1'b1;
        fn   = 1'b1;
        fh   = 1'b1;
      end
      OP_SCF: begin
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b1;
      end
      OP_CCF: begin
        fn = 1'b0;
        fh = 1'b0;
        fc = ~cin;
      end
      OP_BIT: begin
        fz = ((a8 & mask8) == '0);
        fn = 1'b0;
        fh = 1'b1;
      end
      OP_RES: begin
        r8   = a8 & ~mask8;
        use8 = 1'b1;
      end
      OP_SET: begin
        r8   = a8 | mask8;
        use8 = 1'b1;
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        case (req_i.op)
          OP_RLC:  begin r8 = {a8[6:0], a8[7]};   fc = a8[7]; end
          OP_RRC:  begin r8 = {a8[0], a8[7:1]};   fc = a8[0]; end
          OP_RL:   begin r8 = {a8[6:0], cin};     fc = a8[7]; end
          OP_RR:   begin r8 = {cin, a8[7:1]};     fc = a8[0]; end
          OP_SLA:  begin r8 = {a8[6:0], 1'b0};    fc = a8[7]; end
          OP_SRA:  begin r8 = {a8[7], a8[7:1]};   fc = a8[0]; end
          OP_SWAP: begin r8 = {a8[3:0], a8[7:4]}; fc = 1'b0;  end
          default: begin r8 = {1'b0, a8[7:1]};    fc = a8[0]; end
        endcase
        use8 = 1'b1;
        fn   = 1'b0;
        fh   = 1'b0;
        setz = 1'b1;
      end
      default: begin
        // undefined codes: operand_a and flags pass through
        res = req_i.operand_a;
      end
    endcase
    if (use8) res = {{(WordW-ByteW){1'b0}}, r8};
    if (setz) fz = (r8 == '0);
  end

  always_comb begin
    rsp_o.result    = res;
    rsp_o.flags_out = '0;
    rsp_o.flags_out[FlagZ] = fz;
    rsp_o.flags_out[FlagN] = fn;
    rsp_o.flags_out[FlagH] = fh;
    rsp_o.flags_out[FlagC] = fc;
  end

endmodule

### rtl/cpu_alu_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_alu_with_flags: 8-bit CPU ALU with Z/N/H/C flags, stream wrapper
// Input register, single-pass ALU logic, result register.
// ----------------------------------------------------------------------------
// One operation in, one result out. Throughput is one beat per clock while the
// master side accepts results. An accepted beat goes through one input
// register, the ALU logic and one result register to the master side. The
// input side keeps taking beats while a result waits, as long as the result
// register frees up or the input register is empty. Operations: 16-bit add of
// a signed byte, 16-bit add, 8-bit add/adc/sub/sbc/and/xor/or/cp, inc, dec,
// daa, cpl, scf, ccf, bit/res/set and the prefixed rotates and shifts.
// Flags an operation does not touch pass through from flags_in; codes 27..31
// return operand_a with the flags unchanged.
module cpu_alu_with_flags (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [4:0] op, [20:5] operand_a, [36:21] operand_b, [39:37] bit_index,
  // [43:40] flags_in, [47:44] zero
  input  logic [calu_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] result, [19:16] flags_out, [23:20] zero
  output logic [calu_pkg::OutDataW-1:0]    m_axis_tdata
);
  import calu_pkg::*;

  logic     in_vld_q, in_vld_d;
  alu_req_t in_req_q, in_req_d;
  logic     out_vld_q, out_vld_d;
  alu_rsp_t out_rsp_q, out_rsp_d;
  alu_rsp_t core_rsp;
  logic     out_free;   // result register can load this cycle
  logic     in_take;    // input beat accepted

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Unpack the input beat, lowest field first
  always_comb begin
    in_req_d = in_req_q;
    if (in_take) begin
      in_req_d.op        = alu_op_e'(s_axis_tdata[OpW-1:0]);
      in_req_d.operand_a = s_axis_tdata[OpW +: WordW];
      in_req_d.operand_b = s_axis_tdata[OpW+WordW +: WordW];
      in_req_d.bit_index = s_axis_tdata[OpW+2*WordW +: IdxW];
      in_req_d.flags_in  = s_axis_tdata[OpW+2*WordW+IdxW +: FlagW];
    end
  end

  // Input stage empties when its beat moves into the result register
  assign in_vld_d = in_take ? 1'b1 : (in_vld_q && !out_free);

  calu_core u_core (
    .req_i (in_req_q),
    .rsp_o (core_rsp)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    out_rsp_d = out_rsp_q;
    if (out_free) begin
      out_vld_d = in_vld_q;
      if (in_vld_q) out_rsp_d = core_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_req_q  <= in_req_d;
    out_rsp_q <= out_rsp_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-OutPackW){1'b0}},
                          out_rsp_q.flags_out, out_rsp_q.result};

  // An empty input register is always ready to take a beat
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  // A full input register blocked by a stalled result keeps its beat
  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready) |=> in_vld_q)
    else $error("input beat lost while result stalled");

  // A beat leaving the input register lands in the result register
  a_move_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_free) |=> out_vld_q)
    else $error("beat dropped between stages");

  // An accepted input beat always occupies the input register next cycle
  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_vld_q)
    else $error("accepted beat not held");

endmodule
